FILE: design/assert_macros.svh
// Assertion macros used by the top RTL file of the frame CRC block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every clock edge.
`define FCC_ASSERT(lbl, prp) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prp)) \
    else $error("assertion failed");

// Assert that a condition is followed by a consequence in the next cycle.
`define FCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/fcc_pkg.sv
// Package of the frame CRC8/CRC16 compute, check and append block.
// Holds beat payload types, operation and register codes, and reset values.
package fcc_pkg;

  typedef enum logic [2:0] {
    OP_CRC8_COMPUTE  = 3'd0,
    OP_CRC8_VERIFY   = 3'd1,
    OP_CRC8_APPEND   = 3'd2,
    OP_CRC16_COMPUTE = 3'd3,
    OP_CRC16_VERIFY  = 3'd4,
    OP_CRC16_APPEND  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    CFG_CRC8_POLY  = 2'd0,
    CFG_CRC8_START = 2'd1,
    CFG_CRC16_POLY = 2'd2,
    CFG_CRC16_START = 2'd3
  } cfg_idx_e;

  localparam logic [7:0]  CRC8_POLY_RST   = 8'h8C;
  localparam logic [7:0]  CRC8_START_RST  = 8'hFF;
  localparam logic [15:0] CRC16_POLY_RST  = 16'h8408;
  localparam logic [15:0] CRC16_START_RST = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] message_length;
    logic [15:0] seed;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] crc_value;
    logic        check_ok;
    logic        too_short;
    logic        last_byte;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  crc8_poly;
    logic [7:0]  crc8_start;
    logic [15:0] crc16_poly;
    logic [15:0] crc16_start;
  } cfg_t;

endpackage

FILE: design/frame_crc8_crc16_check_append.sv
// Frame CRC8/CRC16 compute, verify and append: one byte beat in, one result beat out.
// Accepts one beat every cycle while the output is not stalled; each result passes
// through the input register, then the result register; the table CRC update is combinational.
// Depends on fcc_pkg, fcc_cfg_regs, fcc_crc_step and assert_macros.svh.
`include "assert_macros.svh"

module frame_crc8_crc16_check_append #(
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fcc_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fcc_pkg::out_beat_t out_data_o
);
  import fcc_pkg::*;

  localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

  cfg_t cfg;

  fcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic      in_valid_q, in_valid_d;
  in_beat_t  in_q;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;
  logic      advance;

  logic [2:0]             held_op_q, held_op_d;
  logic [LENGTH_BITS-1:0] held_len_q, held_len_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [15:0]            crc_q, crc_d;
  logic                   match_q, match_d;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  logic [31:0]            len_ext;
  logic [LENGTH_BITS-1:0] len_trunc;
  logic [2:0]             op;
  logic [LENGTH_BITS-1:0] len, pos, body_end;
  logic [15:0]            crc, start_crc, step_crc, eb;
  logic                   op_valid, is8, is_compute, is_verify, short_f, last, active;
  logic [1:0]             tlen;
  logic [LENGTH_BITS:0]   pos_inc;

  assign len_ext   = 32'(in_q.message_length);
  assign len_trunc = len_ext[LENGTH_BITS-1:0];

  always_comb begin
    unique case (in_q.req_type)
      OP_CRC8_COMPUTE:                 start_crc = {8'h00, in_q.seed[7:0]};
      OP_CRC16_COMPUTE:                start_crc = in_q.seed;
      OP_CRC8_VERIFY, OP_CRC8_APPEND:  start_crc = {8'h00, cfg.crc8_start};
      OP_CRC16_VERIFY, OP_CRC16_APPEND: start_crc = cfg.crc16_start;
      default:                         start_crc = 16'h0000;
    endcase
  end

  assign op  = in_q.first_byte ? in_q.req_type : held_op_q;
  assign len = in_q.first_byte ? ((len_trunc == '0) ? LENGTH_BITS'(1) : len_trunc)
                               : held_len_q;
  assign pos = in_q.first_byte ? '0 : pos_q;
  assign crc = in_q.first_byte ? start_crc : crc_q;

  assign op_valid   = op <= OP_CRC16_APPEND;
  assign is8        = op <= OP_CRC8_APPEND;
  assign is_compute = (op == OP_CRC8_COMPUTE) || (op == OP_CRC16_COMPUTE);
  assign is_verify  = (op == OP_CRC8_VERIFY) || (op == OP_CRC16_VERIFY);
  assign tlen       = (!op_valid || is_compute) ? 2'd0 : (is8 ? 2'd1 : 2'd2);
  assign short_f    = op_valid && !is_compute && (len <= LENGTH_BITS'(2));
  assign pos_inc    = {1'b0, pos} + 1'b1;
  assign last       = pos_inc == {1'b0, len};
  assign active     = op_valid && (pos < len) && !short_f;
  assign body_end   = len - LENGTH_BITS'(tlen);
  assign eb         = {8'h00, (pos != body_end) ? crc[15:8] : crc[7:0]};

  fcc_crc_step u_step (
    .crc_i    (crc),
    .byte_i   (in_q.data_byte),
    .is8_i    (is8),
    .poly8_i  (cfg.crc8_poly),
    .poly16_i (cfg.crc16_poly),
    .crc_o    (step_crc)
  );

  always_comb begin
    crc_d             = crc;
    match_d           = in_q.first_byte ? 1'b1 : match_q;
    out_d.out_byte    = in_q.data_byte;
    out_d.check_ok    = 1'b0;
    out_d.too_short   = short_f;
    out_d.last_byte   = last;
    if (active) begin
      if (pos < body_end) begin
        crc_d = step_crc;
      end else if (is_verify) begin
        if (in_q.data_byte != eb[7:0]) match_d = 1'b0;
        out_d.check_ok = last && match_d;
      end else begin
        out_d.out_byte = eb[7:0];
      end
    end
    out_d.crc_value = crc_d;
    held_op_d  = op;
    held_len_d = len;
    pos_d      = (pos == POS_MAX) ? pos : pos_inc[LENGTH_BITS-1:0];
  end

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_op_q   <= '0;
      held_len_q  <= '0;
      pos_q       <= '0;
      crc_q       <= '0;
      match_q     <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        held_op_q  <= held_op_d;
        held_len_q <= held_len_d;
        pos_q      <= pos_d;
        crc_q      <= crc_d;
        match_q    <= match_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (advance) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FCC_ASSERT(a_ok_on_last, !out_valid_o || !out_data_o.check_ok || out_data_o.last_byte)
  `FCC_ASSERT(a_short_not_ok, !out_valid_o || !out_data_o.too_short || !out_data_o.check_ok)
  `FCC_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q)
  `FCC_ASSERT_NEXT(a_adv_out, advance, out_valid_q)

endmodule

FILE: design/fcc_cfg_regs.sv
// Configuration register file of the frame CRC block.
// Depends on fcc_pkg for the register codes, reset values and cfg_t.
module fcc_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  output fcc_pkg::cfg_t        cfg_o
);
  import fcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CRC8_POLY:   cfg_d.crc8_poly   = cfg_wdata_i[7:0];
        CFG_CRC8_START:  cfg_d.crc8_start  = cfg_wdata_i[7:0];
        CFG_CRC16_POLY:  cfg_d.crc16_poly  = cfg_wdata_i;
        CFG_CRC16_START: cfg_d.crc16_start = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc8_poly   <= CRC8_POLY_RST;
      cfg_q.crc8_start  <= CRC8_START_RST;
      cfg_q.crc16_poly  <= CRC16_POLY_RST;
      cfg_q.crc16_start <= CRC16_START_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/fcc_crc_step.sv
// One-byte update of a reflected CRC8 or CRC16 through a generated table entry.
// Depends on nothing but its ports.
module fcc_crc_step (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  input  logic        is8_i,
  input  logic [7:0]  poly8_i,
  input  logic [15:0] poly16_i,
  output logic [15:0] crc_o
);

  function automatic logic [15:0] table_entry(input logic [7:0] idx, input logic [15:0] poly);
    logic [15:0] r;
    r = {8'h00, idx};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) r = (r >> 1) ^ poly;
      else      r = r >> 1;
    end
    return r;
  endfunction

  logic [15:0] poly;
  logic [15:0] entry;

  assign poly  = is8_i ? {8'h00, poly8_i} : poly16_i;
  assign entry = table_entry(crc_i[7:0] ^ byte_i, poly);
  assign crc_o = is8_i ? {8'h00, entry[7:0]} : ({8'h00, crc_i[15:8]} ^ entry);

endmodule
